>>> design/atsis_pkg.sv
// Shared types, widths and the tree merge function for the table block.
package atsis_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam int unsigned CMD_IW = 10;
  localparam int unsigned CMD_CW = CMD_IW + 1;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INS_SHIFT,
    OP_INS_DISP,
    OP_DEL_AT,
    OP_DEL_VAL,
    OP_SEARCH,
    OP_RSVD6,
    OP_RSVD7
  } table_op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_BADPOS,
    ST_NOTFOUND
  } table_status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INS,
    CM_DISP,
    CM_DEL
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic               cmp_load;
    logic signed [31:0] cmp_value;
    logic signed [31:0] value;
    logic [31:0]        pick;
    logic [CMD_IW-1:0]  pos;
    logic [CMD_CW-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic               vld;
    logic               bad;
    logic signed [31:0] mx;
    logic signed [31:0] mn;
    logic [31:0]        pick;
  } node_t;

  function automatic node_t node_merge(node_t a, node_t b);
    node_t r;
    r.vld  = a.vld | b.vld;
    r.bad  = a.bad | b.bad;
    r.pick = a.pick | b.pick;
    if (!a.vld) begin
      r.mx = b.mx;
      r.mn = b.mn;
    end else if (!b.vld) begin
      r.mx = a.mx;
      r.mn = a.mn;
    end else begin
      r.mx = ($signed(b.mx) > $signed(a.mx)) ? b.mx : a.mx;
      r.mn = ($signed(b.mn) < $signed(a.mn)) ? b.mn : a.mn;
    end
    return r;
  endfunction

endpackage

>>> design/array_table_shift_insert_search.sv
// Errors and unused ops go straight to the result register; append, insert-shift and
// delete-at update the cells, then wait for the registered max/min tree; insert-displace first
// waits for the tree to fetch the displaced entry. Search checks both ends, then bisects over
// the cell flags; delete-by-value runs the search and then the delete-at path.
// Throughput: one item in flight; the next is taken the cycle after the result is registered.
// Reset clears the count, the tree and the handshake state; entries hold garbage until written.
module array_table_shift_insert_search #(
  parameter int unsigned CAPACITY = atsis_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [atsis_pkg::IN_DATA_W-1:0]  in_tdata,   // value[31:0], position[38:32], zero pad
  input  logic [2:0]                       in_tuser,   // op[2:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [atsis_pkg::OUT_DATA_W-1:0] out_tdata,  // found_index, count, maximum, minimum, is_sorted
  output logic [2:0]                       out_tuser   // status[2:0]
);
  import atsis_pkg::*;

  cmd_t               cmd;
  node_t              root;
  node_t              leaf [CAPACITY];
  logic signed [31:0] ent  [CAPACITY];
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] gt;

  atsis_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd_o      (cmd),
    .eq_i       (eq),
    .gt_i       (gt),
    .root_i     (root)
  );

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;
      if (i == 0) begin : g_lo
        assign left_w = ent[i];
      end else begin : g_lo_n
        assign left_w = ent[i-1];
      end
      if (i == CAPACITY - 1) begin : g_hi
        assign right_w = ent[i];
      end else begin : g_hi_n
        assign right_w = ent[i+1];
      end
      atsis_cell #(
        .IDX (i)
      ) u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .left_i  (left_w),
        .right_i (right_w),
        .entry_o (ent[i]),
        .leaf_o  (leaf[i]),
        .eq_o    (eq[i]),
        .gt_o    (gt[i])
      );
    end
  endgenerate

  atsis_tree #(
    .CAPACITY (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .leaf_i (leaf),
    .root_o (root)
  );

endmodule

>>> design/atsis_cell.sv
// One table cell: holds an entry, shifts with its neighbors, compares against a probe.
module atsis_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  atsis_pkg::cmd_t    cmd,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] entry_o,
  output atsis_pkg::node_t   leaf_o,
  output logic               eq_o,
  output logic               gt_o
);
  import atsis_pkg::*;

  localparam logic [CMD_CW-1:0] ME = CMD_CW'(IDX);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;
  logic               eq_r;
  logic               gt_r;
  logic [CMD_CW-1:0]  pos_x;
  logic               vld;
  logic               bad;

  assign pos_x = {1'b0, cmd.pos};

  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.mode)
      CM_INS: begin
        if (ME == pos_x) begin
          entry_nxt = cmd.value;
        end else if ((ME > pos_x) && (ME <= cmd.count)) begin
          entry_nxt = left_i;
        end
      end
      CM_DISP: begin
        if (ME == pos_x) begin
          entry_nxt = cmd.value;
        end else if (ME == cmd.count) begin
          entry_nxt = $signed(cmd.pick);
        end
      end
      CM_DEL: begin
        if (ME >= pos_x) begin
          entry_nxt = right_i;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cmd.cmp_load) begin
      eq_r <= (entry_r == cmd.cmp_value);
      gt_r <= (cmd.cmp_value > entry_r);
    end
  end

  assign vld = (ME < cmd.count);

  generate
    if (IDX == 0) begin : g_head
      assign bad = 1'b0;
    end else begin : g_body
      assign bad = vld && (left_i > entry_r);
    end
  endgenerate

  assign entry_o     = entry_r;
  assign eq_o        = eq_r;
  assign gt_o        = gt_r;
  assign leaf_o.vld  = vld;
  assign leaf_o.bad  = bad;
  assign leaf_o.mx   = entry_r;
  assign leaf_o.mn   = entry_r;
  assign leaf_o.pick = (ME == pos_x) ? entry_r : '0;

endmodule

>>> design/atsis_tree.sv
// Registered reduction tree: max, min, order check and picked entry over all cells.
module atsis_tree #(
  parameter int unsigned CAPACITY = atsis_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  atsis_pkg::node_t leaf_i [CAPACITY],
  output atsis_pkg::node_t root_o
);
  import atsis_pkg::*;

  localparam int unsigned LV = $clog2(CAPACITY);
  localparam int unsigned N2 = 1 << LV;

  node_t leaf_pad [N2];
  node_t node_r   [1:N2-1];

  genvar j;
  generate
    for (j = 0; j < N2; j++) begin : g_pad
      if (j < CAPACITY) begin : g_real
        assign leaf_pad[j] = leaf_i[j];
      end else begin : g_fill
        assign leaf_pad[j] = '0;
      end
    end

    for (j = 1; j < N2; j++) begin : g_node
      if (2 * j >= N2) begin : g_bottom
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            node_r[j] <= '0;
          end else begin
            node_r[j] <= node_merge(leaf_pad[2*j-N2], leaf_pad[2*j+1-N2]);
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            node_r[j] <= '0;
          end else begin
            node_r[j] <= node_merge(node_r[2*j], node_r[2*j+1]);
          end
        end
      end
    end
  endgenerate

  assign root_o = node_r[1];

endmodule

>>> design/atsis_ctrl.sv
// Sequencer: operation decode, bisecting search over cell flags, result register.
module atsis_ctrl #(
  parameter int unsigned CAPACITY = atsis_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [atsis_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [atsis_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]                       out_tuser,
  output atsis_pkg::cmd_t                  cmd_o,
  input  logic [CAPACITY-1:0]              eq_i,
  input  logic [CAPACITY-1:0]              gt_i,
  input  atsis_pkg::node_t                 root_i
);
  import atsis_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = $clog2(IW + 1);
  localparam int unsigned XW = (CW > 7) ? CW : 7;
  localparam logic signed [IW+1:0] ONE = (IW + 2)'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_ENDS,
    S_BIS,
    S_MOD,
    S_SETTLE,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [IW-1:0]        pos_r;
  logic signed [31:0]   value_r;
  cell_mode_t           kind_r;
  logic                 is_del_r;
  logic [2:0]           status_r;
  logic [IW-1:0]        found_r;
  logic [WW-1:0]        wait_r;
  logic signed [IW+1:0] lo_r;
  logic signed [IW+1:0] hi_r;

  logic               out_tvalid_r;
  logic [2:0]         out_status_r;
  logic [6:0]         out_found_r;
  logic [7:0]         out_count_r;
  logic signed [31:0] out_max_r;
  logic signed [31:0] out_min_r;
  logic               out_sorted_r;

  logic [2:0]           op_in;
  logic signed [31:0]   value_in;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        count_x;
  logic                 full;
  logic [IW-1:0]        cnt_m1;
  logic signed [IW+1:0] mid;
  logic [IW-1:0]        mid_idx;
  logic                 accept;

  assign op_in    = in_tuser;
  assign value_in = $signed(in_tdata[31:0]);
  assign pos_x    = XW'(in_tdata[38:32]);
  assign count_x  = XW'(count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign cnt_m1   = IW'(count_r - CW'(1));
  assign mid      = lo_r + ((hi_r - lo_r) >>> 1);
  assign mid_idx  = mid[IW-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      wait_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            value_r  <= value_in;
            pos_r    <= IW'(in_tdata[38:32]);
            status_r <= ST_OK;
            found_r  <= '0;
            wait_r   <= WW'(IW);
            is_del_r <= (op_in == OP_DEL_VAL);
            kind_r   <= CM_DEL;
            state_r  <= S_DONE;
            case (op_in)
              OP_APPEND: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  kind_r  <= CM_INS;
                  pos_r   <= IW'(count_r);
                  state_r <= S_MOD;
                end
              end
              OP_INS_SHIFT, OP_INS_DISP: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else if (pos_x > count_x) begin
                  status_r <= ST_BADPOS;
                end else if (op_in == OP_INS_SHIFT) begin
                  kind_r  <= CM_INS;
                  state_r <= S_MOD;
                end else begin
                  kind_r  <= CM_DISP;
                  state_r <= S_PICK;
                end
              end
              OP_DEL_AT: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                end else if (pos_x >= count_x) begin
                  status_r <= ST_BADPOS;
                end else begin
                  state_r <= S_MOD;
                end
              end
              OP_DEL_VAL, OP_SEARCH: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                end else begin
                  state_r <= S_ENDS;
                end
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_PICK: begin
          if (wait_r == WW'(1)) begin
            state_r <= S_MOD;
          end else begin
            wait_r <= wait_r - WW'(1);
          end
        end
        S_ENDS: begin
          lo_r <= '0;
          hi_r <= $signed({2'b00, cnt_m1});
          if (eq_i[0]) begin
            found_r <= '0;
            pos_r   <= '0;
            state_r <= is_del_r ? S_MOD : S_DONE;
          end else if (eq_i[cnt_m1]) begin
            found_r <= cnt_m1;
            pos_r   <= cnt_m1;
            state_r <= is_del_r ? S_MOD : S_DONE;
          end else begin
            state_r <= S_BIS;
          end
        end
        S_BIS: begin
          if (lo_r > hi_r) begin
            status_r <= ST_NOTFOUND;
            state_r  <= S_DONE;
          end else if (eq_i[mid_idx]) begin
            found_r <= mid_idx;
            pos_r   <= mid_idx;
            state_r <= is_del_r ? S_MOD : S_DONE;
          end else if (gt_i[mid_idx]) begin
            lo_r <= mid + ONE;
          end else begin
            hi_r <= mid - ONE;
          end
        end
        S_MOD: begin
          count_r <= (kind_r == CM_DEL) ? count_r - CW'(1) : count_r + CW'(1);
          wait_r  <= WW'(IW);
          state_r <= S_SETTLE;
        end
        S_SETTLE: begin
          if (wait_r == WW'(1)) begin
            state_r <= S_DONE;
          end else begin
            wait_r <= wait_r - WW'(1);
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= status_r;
            out_found_r  <= 7'(found_r);
            out_count_r  <= 8'(count_r);
            out_max_r    <= root_i.vld ? root_i.mx : '0;
            out_min_r    <= root_i.vld ? root_i.mn : '0;
            out_sorted_r <= !root_i.bad;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_o.mode      = (state_r == S_MOD) ? kind_r : CM_HOLD;
  assign cmd_o.cmp_load  = accept;
  assign cmd_o.cmp_value = value_in;
  assign cmd_o.value     = value_r;
  assign cmd_o.pick      = root_i.pick;
  assign cmd_o.pos       = CMD_IW'(pos_r);
  assign cmd_o.count     = CMD_CW'(count_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_sorted_r, out_min_r, out_max_r, out_count_r, out_found_r};

endmodule
